// ----- rtl/iee_pkg.sv -----
// Package with the character codes and control structs of the infix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

  // Width of the result value on the output stream.
  localparam int unsigned OUT_WIDTH = 64;

  // Character codes that the evaluator recognizes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Request from the sequencer to the shift-add / shift-subtract unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } iee_md_req_t;

  // Status returned by the shift-add / shift-subtract unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } iee_md_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/iee_muldiv.sv -----
// Bit-serial unit: shift-add multiply and restoring divide, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module iee_muldiv #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire iee_pkg::iee_md_req_t req,
  input  wire [VALUE_WIDTH-1:0]   opa,
  input  wire [VALUE_WIDTH-1:0]   opb,
  output iee_pkg::iee_md_rsp_t    rsp,
  output logic [VALUE_WIDTH-1:0]  result
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic                   busy_r;
  logic                   done_r;
  logic                   is_div_r;
  logic [CW-1:0]          cnt_r;
  // Multiplier bits, or dividend bits shifting out and quotient bits shifting in.
  logic [VALUE_WIDTH-1:0] a_r;
  // Multiplicand shifting left, or the divisor.
  logic [VALUE_WIDTH-1:0] b_r;
  // Product, or partial remainder with one guard bit.
  logic [VALUE_WIDTH:0]   acc_r;

  logic [VALUE_WIDTH:0]   rem_shift;
  logic [VALUE_WIDTH:0]   rem_diff;
  logic [VALUE_WIDTH-1:0] prod_nxt;

  // One trial subtraction and one conditional add per cycle.
  always_comb begin
    rem_shift = {acc_r[VALUE_WIDTH-1:0], a_r[VALUE_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, b_r};
    prod_nxt  = a_r[0] ? (acc_r[VALUE_WIDTH-1:0] + b_r) : acc_r[VALUE_WIDTH-1:0];
  end

  // Iteration control and data shift registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r   <= 1'b1;
        is_div_r <= req.is_div;
        cnt_r    <= CW'(VALUE_WIDTH - 1);
        a_r      <= opa;
        b_r      <= opb;
        acc_r    <= '0;
      end else if (busy_r) begin
        if (is_div_r) begin
          if (!rem_diff[VALUE_WIDTH]) begin
            acc_r <= rem_diff;
            a_r   <= {a_r[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            acc_r <= rem_shift;
            a_r   <= {a_r[VALUE_WIDTH-2:0], 1'b0};
          end
        end else begin
          acc_r <= {1'b0, prod_nxt};
          a_r   <= {1'b0, a_r[VALUE_WIDTH-1:1]};
          b_r   <= {b_r[VALUE_WIDTH-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Results are valid in the cycle that done is high.
  assign result     = is_div_r ? a_r : acc_r[VALUE_WIDTH-1:0];
  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.rem_nz = |acc_r;

endmodule

`default_nettype wire

// ----- rtl/infix_expression_evaluator.sv -----
// Top level of the streaming infix expression evaluator.
//
// Usage: characters of an expression enter one beat at a time on the in_ stream
// (in_tdata is the ASCII code, in_tlast marks the final character). Digits build
// a decimal number, + - * / and any other non-space code act as operators with
// * and / binding tighter than + and -, and spaces are skipped. The beat flagged
// last produces one result beat on the out_ stream: out_tdata holds the value,
// sign-extended from VALUE_WIDTH bits, and out_tuser flags a division by zero
// or an inexact division, in which case the value is -1.
// Per beat: a digit or a plain space is taken in S_IDLE; an operator folding
// under + or -, under any other code, or onto a zero divisor passes through
// S_FOLD; one folding under * or a nonzero / also waits in S_WAIT on the
// bit-serial multiply/divide unit that retires one bit a cycle.
// A last beat then passes through S_DONE to load the output register.
// Reset (synchronous, active low) clears the expression state and drops
// out_tvalid. When the receiver stalls, the result is held in the output
// register while the next expression is taken in; only a second result waits.
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [7:0]                          in_tdata,   // [7:0] char_code
  input  wire                                 in_tlast,   // last_char
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [iee_pkg::OUT_WIDTH-1:0]       out_tdata,  // [63:0] value
  output logic                                out_tuser   // error
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [VALUE_WIDTH-1:0]       total_r;
  logic [VALUE_WIDTH-1:0]       term_r;
  logic [VALUE_WIDTH-1:0]       num_r;
  logic [7:0]                   op_r;
  logic                         dp_r;
  logic                         err_r;
  logic [7:0]                   new_op_r;
  logic                         set_op_r;
  logic                         fin_r;
  logic                         neg_q_r;
  logic                         out_valid_r;
  logic [iee_pkg::OUT_WIDTH-1:0] out_value_r;
  logic                         out_error_r;

  logic                         in_beat;
  logic                         is_digit;
  logic                         is_space;
  logic [VALUE_WIDTH-1:0]       num_nxt;
  logic [VALUE_WIDTH-1:0]       sum_nxt;
  logic [VALUE_WIDTH-1:0]       mag_term;
  logic [VALUE_WIDTH-1:0]       mag_num;
  logic                         out_free;
  logic                         md_is_mul;
  logic                         md_is_div;

  iee_pkg::iee_md_req_t         md_req;
  iee_pkg::iee_md_rsp_t         md_rsp;
  logic [VALUE_WIDTH-1:0]       md_result;

  // Character decode and the decimal accumulator step (num * 10 + digit).
  always_comb begin
    in_beat  = in_tvalid && in_tready;
    is_space = (in_tdata == iee_pkg::CH_SPACE);
    is_digit = (in_tdata >= iee_pkg::CH_ZERO) && (in_tdata <= iee_pkg::CH_NINE);
    num_nxt  = (num_r << 3) + (num_r << 1) + VALUE_WIDTH'(in_tdata[3:0]);
    sum_nxt  = total_r + term_r;
    mag_term = term_r[VALUE_WIDTH-1] ? (~term_r + 1'b1) : term_r;
    mag_num  = num_r[VALUE_WIDTH-1] ? (~num_r + 1'b1) : num_r;
    out_free = !out_valid_r || out_tready;
  end

  // Multiply and nonzero divide go to the serial unit; a zero divisor does not.
  always_comb begin
    md_is_mul     = (op_r == iee_pkg::CH_MUL);
    md_is_div     = (op_r == iee_pkg::CH_DIV);
    md_req.start  = (state_r == S_FOLD) && (md_is_mul || (md_is_div && (num_r != '0)));
    md_req.is_div = md_is_div;
  end

  iee_muldiv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .opa   (md_is_div ? mag_term : num_r),
    .opb   (md_is_div ? mag_num : term_r),
    .rsp   (md_rsp),
    .result(md_result)
  );

  // Sequencer: expression state, fold control and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      term_r      <= '0;
      num_r       <= '0;
      op_r        <= iee_pkg::CH_PLUS;
      dp_r        <= 1'b0;
      err_r       <= 1'b0;
      set_op_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register fills from S_DONE and empties when its beat is taken.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            priority if (is_space) begin
              if (in_tlast) begin
                fin_r    <= 1'b1;
                set_op_r <= 1'b0;
                state_r  <= dp_r ? S_FOLD : S_DONE;
              end
            end else if (is_digit) begin
              num_r <= num_nxt;
              dp_r  <= 1'b1;
              if (in_tlast) begin
                fin_r    <= 1'b1;
                set_op_r <= 1'b0;
                state_r  <= S_FOLD;
              end
            end else begin
              new_op_r <= in_tdata;
              set_op_r <= 1'b1;
              fin_r    <= in_tlast;
              state_r  <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          if (md_req.start) begin
            neg_q_r <= term_r[VALUE_WIDTH-1] ^ num_r[VALUE_WIDTH-1];
            state_r <= S_WAIT;
          end else begin
            if (md_is_div) begin
              err_r <= 1'b1;
            end else begin
              total_r <= sum_nxt;
              if (op_r == iee_pkg::CH_PLUS) begin
                term_r <= num_r;
              end else if (op_r == iee_pkg::CH_MINUS) begin
                term_r <= ~num_r + 1'b1;
              end
            end
            num_r <= '0;
            dp_r  <= 1'b0;
            if (set_op_r) begin
              op_r <= new_op_r;
            end
            set_op_r <= 1'b0;
            state_r  <= fin_r ? S_DONE : S_IDLE;
          end
        end
        S_WAIT: begin
          if (md_rsp.done) begin
            if (!md_is_div) begin
              term_r <= md_result;
            end else if (md_rsp.rem_nz) begin
              err_r <= 1'b1;
            end else begin
              term_r <= neg_q_r ? (~md_result + 1'b1) : md_result;
            end
            num_r <= '0;
            dp_r  <= 1'b0;
            if (set_op_r) begin
              op_r <= new_op_r;
            end
            set_op_r <= 1'b0;
            state_r  <= fin_r ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_error_r <= err_r;
            out_value_r <= err_r ? '1 : iee_pkg::OUT_WIDTH'(signed'(sum_nxt));
            total_r     <= '0;
            term_r      <= '0;
            num_r       <= '0;
            op_r        <= iee_pkg::CH_PLUS;
            dp_r        <= 1'b0;
            err_r       <= 1'b0;
            set_op_r    <= 1'b0;
            fin_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_error_r;

`ifndef ASSERT_OFF
  // A finished result waits in S_DONE while the held one is not taken.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result left S_DONE while the output register was full");

  // An error result always carries the value -1.
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_value_r == '1))
    else $error("error result without value -1");

  // The serial unit is started only when it is free.
  a_md_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> !md_rsp.busy)
    else $error("multiply/divide started while busy");

  // No input is taken while the serial unit is still working.
  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !md_rsp.busy)
    else $error("sequencer idle while multiply/divide busy");
`endif

endmodule

`default_nettype wire
